[src/swpl_pkg.sv]
// Package for the sorted word prefix lookup block.
// Types, codes, character constants and character-class helpers.
// No dependencies.
package swpl_pkg;

    localparam int KEY_LEN_DEF  = 64;
    localparam int WORD_LEN_DEF = 256;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic signed [2:0] V_KEY_BEFORE  = -3'sd2;
    localparam logic signed [2:0] V_KEY_PREFIX  = -3'sd1;
    localparam logic signed [2:0] V_EQUAL       = 3'sd0;
    localparam logic signed [2:0] V_WORD_PREFIX = 3'sd1;
    localparam logic signed [2:0] V_WORD_BEFORE = 3'sd2;

    localparam logic [2:0] CFG_FOLD  = 3'd0;
    localparam logic [2:0] CFG_DICT  = 3'd1;
    localparam logic [2:0] CFG_EXACT = 3'd2;
    localparam logic [2:0] CFG_NUM   = 3'd3;
    localparam logic [2:0] CFG_FEND  = 3'd4;

    typedef enum logic [1:0] {
        F_KEY_CH   = 2'd0,
        F_KEY_END  = 2'd1,
        F_WORD_CH  = 2'd2,
        F_WORD_END = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_PRINT  = 2'd1,
        PH_DONE   = 2'd2,
        PH_LOAD   = 2'd3
    } t_phase;

    typedef struct packed {
        logic we_key;
        logic we_word;
        logic start;
        logic numeric;
    } t_cwr_ctl;

    typedef struct packed {
        logic              done;
        logic signed [2:0] v;
    } t_cmp_res;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic keep_dict(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ))
            || (c == CH_SP) || (c == CH_TAB);
    endfunction

    function automatic logic [7:0] fold_ch(input logic [7:0] c, input logic en);
        return (en && (c >= CH_UA) && (c <= CH_UZ)) ? c + CASE_OFS : c;
    endfunction

endpackage

[src/swpl_if.sv]
// Stream interfaces of the sorted word prefix lookup block.
// Depends on nothing; payload widths are fixed.
interface swpl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] ch;
    modport source (output valid, func, ch, input ready);
    modport sink (input valid, func, ch, output ready);
endinterface

interface swpl_out_if;
    logic              valid;
    logic              ready;
    logic signed [2:0] verdict;
    logic              show;
    logic              done_res;
    logic              too_long;
    modport source (output valid, verdict, show, done_res, too_long, input ready);
    modport sink (input valid, verdict, show, done_res, too_long, output ready);
endinterface

[src/swpl_cmp.sv]
// Compare engine: holds the canonical key and word buffers and walks them.
// Byte order with prefix classes, or signed decimal compare. Uses swpl_pkg.
module swpl_cmp import swpl_pkg::*; #(
    parameter int KEY_LEN  = KEY_LEN_DEF,
    parameter int WORD_LEN = WORD_LEN_DEF,
    localparam int KA   = $clog2(KEY_LEN),
    localparam int WA   = $clog2(WORD_LEN),
    localparam int KP_W = $clog2(KEY_LEN + 1),
    localparam int WP_W = $clog2(WORD_LEN + 1),
    localparam int CW   = (KP_W > WP_W) ? KP_W : WP_W
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cwr_ctl        i_ctl,
    input  logic [CW-1:0]   i_waddr,
    input  logic [7:0]      i_wdata,
    input  logic [KP_W-1:0] i_klen,
    input  logic [WP_W-1:0] i_wlen,
    output t_cmp_res        o_res
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RD   = 3'b010,
        C_EV   = 3'b100
    } t_cst;

    typedef enum logic [12:0] {
        Q_BYTE = 13'b0000000000001,
        Q_SPS  = 13'b0000000000010,
        Q_DGS  = 13'b0000000000100,
        Q_SPT  = 13'b0000000001000,
        Q_DGT  = 13'b0000000010000,
        Q_MID  = 13'b0000000100000,
        Q_XS   = 13'b0000001000000,
        Q_XT   = 13'b0000010000000,
        Q_OV   = 13'b0000100000000,
        Q_DOT  = 13'b0001000000000,
        Q_FR   = 13'b0010000000000,
        Q_RS   = 13'b0100000000000,
        Q_RT   = 13'b1000000000000
    } t_step;

    logic [7:0] ckey  [KEY_LEN];
    logic [7:0] cword [WORD_LEN];

    t_cst            r_st, n_st;
    t_step           r_step, n_step;
    logic [KP_W-1:0] r_pa, n_pa, r_si, n_si, r_sie, n_sie, r_sxe, n_sxe;
    logic [WP_W-1:0] r_pb, n_pb, r_ti, n_ti, r_tie, n_tie, r_txe, n_txe;
    logic            r_neg_s, n_neg_s, r_neg_t, n_neg_t;
    logic [7:0]      r_kq, r_wq;
    t_cmp_res        r_res, n_res;

    logic [7:0]        ck, cw;
    logic              same;
    logic signed [2:0] v_ss, v_nss, v_ts, v_d;
    logic [KP_W-1:0]   ls;
    logic [WP_W-1:0]   lt;
    logic [CW-1:0]     m;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we_key) begin
            ckey[i_waddr[KA-1:0]] <= i_wdata;
        end
        if (i_ctl.we_word) begin
            cword[i_waddr[WA-1:0]] <= i_wdata;
        end
        r_kq <= ckey[r_pa[KA-1:0]];
        r_wq <= cword[r_pb[WA-1:0]];
    end

    always_comb begin
        ck    = (r_pa < i_klen) ? r_kq : CH_NUL;
        cw    = (r_pb < i_wlen) ? r_wq : CH_NUL;
        same  = (r_neg_s == r_neg_t);
        v_ss  = r_neg_s ? V_WORD_BEFORE : V_KEY_BEFORE;
        v_nss = r_neg_s ? V_KEY_BEFORE : V_WORD_BEFORE;
        v_ts  = r_neg_t ? V_WORD_BEFORE : V_KEY_BEFORE;
        v_d   = (cw > ck) ? v_ss : v_nss;
        ls    = r_sie - r_si;
        lt    = r_tie - r_ti;
        if (!same) begin
            m = '0;
        end else if (CW'(ls) < CW'(lt)) begin
            m = CW'(ls);
        end else begin
            m = CW'(lt);
        end

        n_st    = r_st;
        n_step  = r_step;
        n_pa    = r_pa;
        n_pb    = r_pb;
        n_si    = r_si;
        n_sie   = r_sie;
        n_sxe   = r_sxe;
        n_ti    = r_ti;
        n_tie   = r_tie;
        n_txe   = r_txe;
        n_neg_s = r_neg_s;
        n_neg_t = r_neg_t;
        n_res   = r_res;
        n_res.done = 1'b0;

        case (r_st)
            C_IDLE: begin
                if (i_ctl.start) begin
                    n_st    = C_RD;
                    n_step  = i_ctl.numeric ? Q_SPS : Q_BYTE;
                    n_pa    = '0;
                    n_pb    = '0;
                    n_neg_s = 1'b0;
                    n_neg_t = 1'b0;
                end
            end
            C_RD: begin
                n_st = C_EV;
            end
            C_EV: begin
                n_st = C_RD;
                case (r_step)
                    Q_BYTE: begin
                        if (ck == cw) begin
                            if (ck == CH_NUL) begin
                                n_res = '{done: 1'b1, v: V_EQUAL};
                            end else begin
                                n_pa = r_pa + 1'b1;
                                n_pb = r_pb + 1'b1;
                            end
                        end else if (ck == CH_NUL) begin
                            n_res = '{done: 1'b1, v: V_KEY_PREFIX};
                        end else if (cw == CH_NUL) begin
                            n_res = '{done: 1'b1, v: V_WORD_PREFIX};
                        end else begin
                            n_res = '{done: 1'b1,
                                      v: (ck < cw) ? V_KEY_BEFORE : V_WORD_BEFORE};
                        end
                    end
                    Q_SPS: begin
                        if (is_space(ck)) begin
                            n_pa = r_pa + 1'b1;
                        end else begin
                            n_step = Q_DGS;
                            if (ck == CH_MINUS) begin
                                n_neg_s = 1'b1;
                                n_pa    = r_pa + 1'b1;
                                n_si    = r_pa + 1'b1;
                            end else begin
                                n_si = r_pa;
                            end
                        end
                    end
                    Q_DGS: begin
                        if (is_digit(ck)) begin
                            n_pa = r_pa + 1'b1;
                        end else begin
                            n_sie  = r_pa;
                            n_step = Q_SPT;
                        end
                    end
                    Q_SPT: begin
                        if (is_space(cw)) begin
                            n_pb = r_pb + 1'b1;
                        end else begin
                            n_step = Q_DGT;
                            if (cw == CH_MINUS) begin
                                n_neg_t = 1'b1;
                                n_pb    = r_pb + 1'b1;
                                n_ti    = r_pb + 1'b1;
                            end else begin
                                n_ti = r_pb;
                            end
                        end
                    end
                    Q_DGT: begin
                        if (is_digit(cw)) begin
                            n_pb = r_pb + 1'b1;
                        end else begin
                            n_tie  = r_pb;
                            n_step = Q_MID;
                        end
                    end
                    Q_MID: begin
                        n_sxe  = r_sie - m[KP_W-1:0];
                        n_txe  = r_tie - m[WP_W-1:0];
                        n_pa   = r_si;
                        n_pb   = r_ti;
                        n_step = Q_XS;
                    end
                    Q_XS: begin
                        if (r_pa < r_sxe) begin
                            if (ck != CH_0) begin
                                n_res = '{done: 1'b1, v: v_nss};
                            end else begin
                                n_pa = r_pa + 1'b1;
                            end
                        end else begin
                            n_step = Q_XT;
                        end
                    end
                    Q_XT: begin
                        if (r_pb < r_txe) begin
                            if (cw != CH_0) begin
                                n_res = '{done: 1'b1, v: v_ts};
                            end else begin
                                n_pb = r_pb + 1'b1;
                            end
                        end else begin
                            n_pa   = r_sxe;
                            n_pb   = r_txe;
                            n_step = Q_OV;
                        end
                    end
                    Q_OV: begin
                        if (r_pa < r_sie) begin
                            if (ck != cw) begin
                                n_res = '{done: 1'b1, v: v_d};
                            end else begin
                                n_pa = r_pa + 1'b1;
                                n_pb = r_pb + 1'b1;
                            end
                        end else begin
                            n_pa   = r_sie;
                            n_pb   = r_tie;
                            n_step = Q_DOT;
                        end
                    end
                    Q_DOT: begin
                        if (ck == CH_DOT) begin
                            n_pa = r_pa + 1'b1;
                        end
                        if (cw == CH_DOT) begin
                            n_pb = r_pb + 1'b1;
                        end
                        n_step = same ? Q_FR : Q_RS;
                    end
                    Q_FR: begin
                        if (is_digit(ck) && is_digit(cw)) begin
                            if (ck != cw) begin
                                n_res = '{done: 1'b1, v: v_d};
                            end else begin
                                n_pa = r_pa + 1'b1;
                                n_pb = r_pb + 1'b1;
                            end
                        end else begin
                            n_step = Q_RS;
                        end
                    end
                    Q_RS: begin
                        if (is_digit(ck)) begin
                            if (ck != CH_0) begin
                                n_res = '{done: 1'b1, v: v_nss};
                            end else begin
                                n_pa = r_pa + 1'b1;
                            end
                        end else begin
                            n_step = Q_RT;
                        end
                    end
                    Q_RT: begin
                        if (is_digit(cw)) begin
                            if (cw != CH_0) begin
                                n_res = '{done: 1'b1, v: v_ts};
                            end else begin
                                n_pb = r_pb + 1'b1;
                            end
                        end else begin
                            n_res = '{done: 1'b1, v: V_EQUAL};
                        end
                    end
                    default: begin
                        n_step = Q_BYTE;
                    end
                endcase
                if (n_res.done) begin
                    n_st = C_IDLE;
                end
            end
            default: begin
                n_st = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= C_IDLE;
            r_step     <= Q_BYTE;
            r_res.done <= 1'b0;
        end else begin
            r_st       <= n_st;
            r_step     <= n_step;
            r_res.done <= n_res.done;
        end
        r_res.v <= n_res.v;
        r_pa    <= n_pa;
        r_pb    <= n_pb;
        r_si    <= n_si;
        r_sie   <= n_sie;
        r_sxe   <= n_sxe;
        r_ti    <= n_ti;
        r_tie   <= n_tie;
        r_txe   <= n_txe;
        r_neg_s <= n_neg_s;
        r_neg_t <= n_neg_t;
    end

    assign o_res = r_res;

endmodule

[src/sorted_word_prefix_lookup.sv]
// Top level of the sorted word prefix lookup block.
// Uses swpl_pkg, swpl_if (swpl_in_if, swpl_out_if) and swpl_cmp.
//
// Key and word characters are taken one item per cycle and stored raw. A word
// end starts a sequencer that canonicalises key and word into scratch buffers
// and then walks them; every step reads the buffers through a registered port.
// The number of compare steps is at most the canonical word length plus one
// in byte order and about the sum of both lengths in numeric mode. Input is
// held off while that runs, and while a result waits that the sink has not
// taken. Only one item is in work at a time.
module sorted_word_prefix_lookup import swpl_pkg::*; #(
    parameter int KEY_LEN  = KEY_LEN_DEF,
    parameter int WORD_LEN = WORD_LEN_DEF,
    localparam int KA   = $clog2(KEY_LEN),
    localparam int WA   = $clog2(WORD_LEN),
    localparam int KP_W = $clog2(KEY_LEN + 1),
    localparam int WP_W = $clog2(WORD_LEN + 1),
    localparam int CW   = (KP_W > WP_W) ? KP_W : WP_W
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swpl_in_if.sink     i_in,
    swpl_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CRD  = 4'b0010,
        S_CEV  = 4'b0100,
        S_CMP  = 4'b1000
    } t_st;

    logic [7:0] key_store  [KEY_LEN];
    logic [7:0] word_store [WORD_LEN];

    logic r_fold, r_dict, r_exact, r_num;
    logic [7:0] r_fe;

    t_st             r_st, n_st;
    t_phase          r_phase, n_phase;
    logic [KP_W-1:0] r_kc, n_kc, r_klen, n_klen;
    logic [WP_W-1:0] r_wc, n_wc, r_wlen, n_wlen;
    logic            r_csel, n_csel;
    logic [CW-1:0]   r_ri, n_ri, r_co, n_co;
    logic [7:0]      r_rq;

    logic              r_ov, n_ov;
    logic signed [2:0] r_verdict, n_verdict;
    logic              r_show, n_show, r_done, n_done, r_tl, n_tl;

    logic            in_ready, acc, kwe, wwe, fin, match;
    logic [KA-1:0]   kaddr;
    logic [WA-1:0]   waddr;
    logic [KP_W-1:0] kc0;
    logic [WP_W-1:0] wc_eff;
    t_phase          ph_eff;
    logic [CW-1:0]   cnt;
    logic [7:0]      wd;
    t_cwr_ctl        ctl;
    t_cmp_res        res;

    swpl_cmp #(
        .KEY_LEN  (KEY_LEN),
        .WORD_LEN (WORD_LEN)
    ) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_waddr (r_co),
        .i_wdata (wd),
        .i_klen  (r_klen),
        .i_wlen  (r_wlen),
        .o_res   (res)
    );

    assign in_ready   = (r_st == S_IDLE) && (!r_ov || o_out.ready);
    assign i_in.ready = in_ready;
    assign acc        = i_in.valid && in_ready;

    always_comb begin
        ph_eff = (r_phase == PH_LOAD) ? PH_SEARCH : r_phase;
        wc_eff = (r_phase == PH_LOAD) ? '0 : r_wc;
        kc0    = (r_phase != PH_LOAD) ? '0 : r_kc;
        cnt    = r_csel ? CW'(r_wc) : CW'(r_kc);
        wd     = fold_ch(r_rq, r_fold);
        match  = (res.v == V_EQUAL) || ((res.v == V_KEY_PREFIX) && !r_exact);

        n_st      = r_st;
        n_phase   = r_phase;
        n_kc      = r_kc;
        n_wc      = r_wc;
        n_klen    = r_klen;
        n_wlen    = r_wlen;
        n_csel    = r_csel;
        n_ri      = r_ri;
        n_co      = r_co;
        n_ov      = r_ov && !o_out.ready;
        n_verdict = r_verdict;
        n_show    = r_show;
        n_done    = r_done;
        n_tl      = r_tl;
        kwe       = 1'b0;
        wwe       = 1'b0;
        kaddr     = kc0[KA-1:0];
        waddr     = wc_eff[WA-1:0];
        fin       = 1'b0;
        ctl       = '0;
        ctl.numeric = r_num;

        case (r_st)
            S_IDLE: begin
                if (acc) begin
                    case (i_in.func)
                        F_KEY_CH: begin
                            n_phase = PH_LOAD;
                            n_kc    = kc0;
                            if (kc0 < KP_W'(KEY_LEN)) begin
                                kwe  = 1'b1;
                                n_kc = kc0 + 1'b1;
                            end
                        end
                        F_KEY_END: begin
                            n_phase = PH_SEARCH;
                            n_wc    = '0;
                        end
                        F_WORD_CH: begin
                            n_phase = ph_eff;
                            n_wc    = wc_eff;
                            if (ph_eff != PH_DONE) begin
                                if (wc_eff >= WP_W'(WORD_LEN - 2)) begin
                                    n_phase   = PH_DONE;
                                    n_wc      = '0;
                                    n_ov      = 1'b1;
                                    n_verdict = V_EQUAL;
                                    n_show    = 1'b0;
                                    n_done    = 1'b1;
                                    n_tl      = 1'b1;
                                end else begin
                                    wwe  = 1'b1;
                                    n_wc = wc_eff + 1'b1;
                                end
                            end
                        end
                        F_WORD_END: begin
                            n_phase = ph_eff;
                            n_wc    = wc_eff;
                            if (ph_eff == PH_DONE) begin
                                n_wc      = '0;
                                n_ov      = 1'b1;
                                n_verdict = V_EQUAL;
                                n_show    = 1'b0;
                                n_done    = 1'b1;
                                n_tl      = 1'b0;
                            end else begin
                                n_st   = S_CRD;
                                n_csel = 1'b0;
                                n_ri   = '0;
                                n_co   = '0;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
            S_CRD: begin
                if (r_ri >= cnt) begin
                    fin = 1'b1;
                end else begin
                    n_st = S_CEV;
                end
            end
            S_CEV: begin
                n_st = S_CRD;
                if ((r_rq == CH_NUL) || (r_rq == r_fe)) begin
                    fin = 1'b1;
                end else if (r_dict && !keep_dict(r_rq)) begin
                    n_ri = r_ri + 1'b1;
                end else begin
                    ctl.we_key  = !r_csel;
                    ctl.we_word = r_csel;
                    n_co        = r_co + 1'b1;
                    n_ri        = r_ri + 1'b1;
                end
            end
            S_CMP: begin
                if (res.done) begin
                    n_st      = S_IDLE;
                    n_wc      = '0;
                    n_ov      = 1'b1;
                    n_verdict = res.v;
                    n_tl      = 1'b0;
                    if (match) begin
                        n_phase = PH_PRINT;
                        n_show  = 1'b1;
                        n_done  = 1'b0;
                    end else if ((r_phase == PH_SEARCH) && (res.v > V_EQUAL)) begin
                        n_show = 1'b0;
                        n_done = 1'b0;
                    end else begin
                        n_phase = PH_DONE;
                        n_show  = 1'b0;
                        n_done  = 1'b1;
                    end
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase

        // end of one canonical pass
        if (fin) begin
            if (!r_csel) begin
                n_klen = r_co[KP_W-1:0];
                n_csel = 1'b1;
                n_ri   = '0;
                n_co   = '0;
                n_st   = S_CRD;
            end else begin
                n_wlen    = r_co[WP_W-1:0];
                ctl.start = 1'b1;
                n_st      = S_CMP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (kwe) begin
            key_store[kaddr] <= i_in.ch;
        end
        if (wwe) begin
            word_store[waddr] <= i_in.ch;
        end
        r_rq <= r_csel ? word_store[r_ri[WA-1:0]] : key_store[r_ri[KA-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold  <= 1'b0;
            r_dict  <= 1'b0;
            r_exact <= 1'b0;
            r_num   <= 1'b0;
            r_fe    <= 8'h00;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FOLD:  r_fold  <= i_cfg_data[0];
                CFG_DICT:  r_dict  <= i_cfg_data[0];
                CFG_EXACT: r_exact <= i_cfg_data[0];
                CFG_NUM:   r_num   <= i_cfg_data[0];
                CFG_FEND:  r_fe    <= i_cfg_data;
                default: begin
                    r_fe <= r_fe;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_phase <= PH_SEARCH;
            r_kc    <= '0;
            r_wc    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_phase <= n_phase;
            r_kc    <= n_kc;
            r_wc    <= n_wc;
            r_ov    <= n_ov;
        end
        r_klen    <= n_klen;
        r_wlen    <= n_wlen;
        r_csel    <= n_csel;
        r_ri      <= n_ri;
        r_co      <= n_co;
        r_verdict <= n_verdict;
        r_show    <= n_show;
        r_done    <= n_done;
        r_tl      <= n_tl;
    end

    assign o_out.valid    = r_ov;
    assign o_out.verdict  = r_verdict;
    assign o_out.show     = r_show;
    assign o_out.done_res = r_done;
    assign o_out.too_long = r_tl;

endmodule

[tb/sorted_word_prefix_lookup_tb.sv]
// Testbench for sorted_word_prefix_lookup: drives key and word items, predicts each
// verdict with its own lookup model, and checks results under random stalls.
// Depends on swpl_pkg, swpl_in_if, swpl_out_if and the block itself.
`timescale 1ns / 100ps

module sorted_word_prefix_lookup_tb;
    import swpl_pkg::*;

    localparam int KEY_CAP   = 64;
    localparam int WORD_CAP  = 256;
    localparam int SETTLE    = 1400;

    typedef logic [7:0] t_buf [0:299];
    typedef logic [7:0] t_bytes [$];

    typedef struct {
        logic signed [2:0] verdict;
        logic              show;
        logic              done_res;
        logic              too_long;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    swpl_in_if  in_if ();
    swpl_out_if out_if ();

    sorted_word_prefix_lookup dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_out      (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // lookup model state
    logic       m_fold, m_dict, m_exact, m_num;
    logic [7:0] m_fend;
    t_buf       key_mem, word_mem;
    int         key_n, word_n;
    t_phase     scan;
    t_verdict   verdict_q [$];

    int  errors = 0;
    bit  calm = 0;
    int  hold_req = 0;

    function automatic bit dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic t_buf canon(t_buf src, int n);
        t_buf dst;
        int o;
        logic [7:0] c;
        o = 0;
        foreach (dst[i]) dst[i] = 8'h00;
        for (int i = 0; i < n; i++) begin
            c = src[i];
            if (c == 8'h00 || c == m_fend) break;
            if (m_dict && !(dig(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
                            || c == " " || c == 8'd9)) continue;
            if (m_fold && c >= "A" && c <= "Z") c = c + 8'd32;
            dst[o] = c;
            o++;
        end
        return dst;
    endfunction

    function automatic int order_cmp(t_buf s, t_buf t);
        int i;
        i = 0;
        while (s[i] == t[i]) begin
            if (s[i] == 8'h00) return 0;
            i++;
        end
        if (s[i] == 8'h00) return -1;
        if (t[i] == 8'h00) return 1;
        return (s[i] < t[i]) ? -2 : 2;
    endfunction

    function automatic int sgn(int a);
        return (a > 0) ? 1 : -1;
    endfunction

    function automatic int value_cmp(t_buf s, t_buf t);
        int i, j, ie, je, p, q, ss, ts, a, b;
        i = 0; j = 0; ss = -2; ts = -2; a = 0;
        while (blank(s[i])) i++;
        while (blank(t[j])) j++;
        if (s[i] == "-") begin i++; ss = 2; end
        if (t[j] == "-") begin j++; ts = 2; end
        ie = i;
        while (dig(s[ie])) ie++;
        je = j;
        while (dig(t[je])) je++;
        p = ie; q = je;
        if (ss == ts)
            while (q > j && p > i) begin
                p--; q--;
                b = int'(t[q]) - int'(s[p]);
                if (b != 0) a = b;
            end
        while (p > i) begin p--; if (s[p] != "0") return -ss; end
        while (q > j) begin q--; if (t[q] != "0") return ts; end
        if (a != 0) return sgn(a) * ss;
        p = ie; if (s[p] == ".") p++;
        q = je; if (t[q] == ".") q++;
        if (ss == ts)
            while (dig(s[p]) && dig(t[q])) begin
                b = int'(t[q]) - int'(s[p]);
                p++; q++;
                if (b != 0) return sgn(b) * ss;
            end
        while (dig(s[p])) begin if (s[p] != "0") return -ss; p++; end
        while (dig(t[q])) begin if (t[q] != "0") return ts; q++; end
        return 0;
    endfunction

    function automatic void expect_verdict(int v, bit sh, bit dn, bit tl);
        t_verdict e;
        e.verdict  = 3'(v);
        e.show     = sh;
        e.done_res = dn;
        e.too_long = tl;
        verdict_q.push_back(e);
    endfunction

    function automatic void lookup_step(t_func f, logic [7:0] c);
        int v;
        t_buf ck, cw;
        if (f == F_KEY_CH) begin
            if (scan != PH_LOAD) begin
                key_n = 0;
                scan = PH_LOAD;
            end
            if (key_n < KEY_CAP) begin
                key_mem[key_n] = c;
                key_n++;
            end
            return;
        end
        if (f == F_KEY_END || scan == PH_LOAD) begin
            scan = PH_SEARCH;
            word_n = 0;
            if (f == F_KEY_END) return;
        end
        if (f == F_WORD_CH) begin
            if (scan == PH_DONE) return;
            if (word_n >= WORD_CAP - 2) begin
                scan = PH_DONE;
                word_n = 0;
                expect_verdict(0, 0, 1, 1);
                return;
            end
            word_mem[word_n] = c;
            word_n++;
            return;
        end
        if (scan == PH_DONE) begin
            word_n = 0;
            expect_verdict(0, 0, 1, 0);
            return;
        end
        ck = canon(key_mem, key_n);
        cw = canon(word_mem, word_n);
        word_n = 0;
        v = m_num ? value_cmp(ck, cw) : order_cmp(ck, cw);
        if (v == 0 || (v == -1 && !m_exact)) begin
            scan = PH_PRINT;
            expect_verdict(v, 1, 0, 0);
        end else if (scan == PH_SEARCH && v > 0) begin
            expect_verdict(v, 0, 0, 0);
        end else begin
            scan = PH_DONE;
            expect_verdict(v, 0, 1, 0);
        end
    endfunction

    task automatic send_item(t_func f, logic [7:0] c);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.func  <= f;
        in_if.ch    <= c;
        do @(posedge i_clk); while (!in_if.ready);
        lookup_step(f, c);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_FOLD:  m_fold  = data[0];
            CFG_DICT:  m_dict  = data[0];
            CFG_EXACT: m_exact = data[0];
            CFG_NUM:   m_num   = data[0];
            default:   m_fend  = data;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_key(t_bytes k, bit close);
        foreach (k[i]) send_item(F_KEY_CH, k[i]);
        if (close) send_item(F_KEY_END, 8'($urandom));
    endtask

    task automatic send_word(t_bytes w);
        foreach (w[i]) send_item(F_WORD_CH, w[i]);
        send_item(F_WORD_END, 8'($urandom));
    endtask

    function automatic t_bytes to_bytes(string s);
        t_bytes b;
        for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
        return b;
    endfunction

    function automatic logic [7:0] text_ch();
        string pool;
        pool = "aAbBcCzZ09-. ,_";
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0) return 8'd9;
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic t_bytes text_word(int n);
        t_bytes w;
        repeat (n) w.push_back(text_ch());
        return w;
    endfunction

    function automatic t_bytes number_word();
        t_bytes w;
        repeat ($urandom_range(0, 2)) w.push_back(" ");
        if ($urandom_range(0, 2) == 0) w.push_back("-");
        repeat ($urandom_range(0, 4)) w.push_back(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 1) begin
            w.push_back(".");
            repeat ($urandom_range(0, 3)) w.push_back(8'("0" + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 12) == 0) w.push_back(text_ch());
        return w;
    endfunction

    task automatic test_basic_lookup();
        send_key(to_bytes("ab"), 1);
        send_word(to_bytes("a"));
        send_word({8'h00, 8'hFF});
        send_word(to_bytes("ab"));
        send_word(to_bytes("abc"));
        send_word(to_bytes("b"));
        send_item(F_WORD_CH, 8'hFF);
        send_item(F_WORD_END, 8'h00);
        send_key({8'hFF, 8'h01}, 0);
        send_word({8'hFF});
        send_item(F_KEY_END, 8'hFF);
        send_word({8'hFF, 8'h01});
        send_word(to_bytes("zz"));
    endtask

    task automatic test_key_overflow();
        t_bytes k;
        k = text_word(70);
        send_key(k, 1);
        send_word(k);
        k = k[0:KEY_CAP - 1];
        send_word(k);
    endtask

    task automatic test_word_overflow();
        send_key(to_bytes("m"), 1);
        send_word(text_word(WORD_CAP - 1));
        send_word(to_bytes("x"));
        send_key(to_bytes("m"), 1);
        send_word(text_word(WORD_CAP - 2));
    endtask

    // sink holds off while words keep coming, so the input stalls
    task automatic test_output_stall();
        send_key(to_bytes("b"), 1);
        hold_req = 400;
        while (hold_req != 0) @(posedge i_clk);
        repeat (4) send_word(to_bytes("a"));
    endtask

    task automatic test_random_lookup(bit fold, bit dict, bit exact, bit num,
                                      logic [7:0] fend, int items);
        int start;
        t_bytes key, w;
        wait_idle();
        cfg_write(CFG_FOLD, {7'd0, fold});
        cfg_write(CFG_DICT, {7'd0, dict});
        cfg_write(CFG_EXACT, {7'd0, exact});
        cfg_write(CFG_NUM, {7'd0, num});
        cfg_write(CFG_FEND, fend);
        start = 0;
        while (start < items) begin
            key = num ? number_word() : text_word($urandom_range(1, 6));
            send_key(key, $urandom_range(0, 9) != 0);
            start += key.size() + 1;
            repeat ($urandom_range(2, 5)) begin
                case ($urandom_range(0, 5))
                    0, 1: begin
                        w = key;
                        if (w.size() > 0 && $urandom_range(0, 1) == 1)
                            w[w.size() - 1] = w[w.size() - 1] - 8'd1;
                    end
                    2, 3: begin
                        w = key;
                        w = {w, (num ? number_word() : text_word($urandom_range(0, 3)))};
                    end
                    default: w = num ? number_word() : text_word($urandom_range(0, 8));
                endcase
                if ($urandom_range(0, 19) == 0 && !calm)
                    send_item(t_func'($urandom_range(0, 3)), 8'($urandom));
                send_word(w);
                start += w.size() + 1;
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_verdict e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result verdict %0d", $time, out_if.verdict);
                errors++;
            end else begin
                e = verdict_q.pop_front();
                if (out_if.verdict !== e.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d", $time, e.verdict,
                             out_if.verdict);
                    errors++;
                end
                if (out_if.show !== e.show) begin
                    $display("%0t: show expected %0d actual %0d", $time, e.show, out_if.show);
                    errors++;
                end
                if (out_if.done_res !== e.done_res) begin
                    $display("%0t: done_res expected %0d actual %0d", $time, e.done_res,
                             out_if.done_res);
                    errors++;
                end
                if (out_if.too_long !== e.too_long) begin
                    $display("%0t: too_long expected %0d actual %0d", $time, e.too_long,
                             out_if.too_long);
                    errors++;
                end
            end
        end
    end

    // result receiver
    initial begin
        int n;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                out_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int spin;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_FOLD;
        i_cfg_data  <= 8'h00;
        in_if.valid <= 1'b0;
        in_if.func  <= F_KEY_END;
        in_if.ch    <= 8'h00;
        m_fold = 0; m_dict = 0; m_exact = 0; m_num = 0; m_fend = 8'h00;
        key_n = 0; word_n = 0; scan = PH_SEARCH;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_lookup();
        test_key_overflow();
        test_word_overflow();
        test_output_stall();
        test_random_lookup(0, 0, 0, 0, 8'h00, 10);
        test_random_lookup(1, 1, 0, 0, ",", 10);
        test_random_lookup(0, 0, 1, 0, 8'hFF, 10);
        test_random_lookup(1, 0, 1, 0, 8'd9, 10);
        test_random_lookup(0, 0, 0, 1, 8'h00, 10);
        calm = 1;
        test_random_lookup(0, 1, 1, 1, 8'hFF, 10);

        in_if.valid <= 1'b0;
        spin = 0;
        while (verdict_q.size() != 0 && spin < 100000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (verdict_q.size() != 0)
                $display("%0t: %0d results never arrived", $time, verdict_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sorted_word_prefix_lookup.f]
src/swpl_pkg.sv
src/swpl_if.sv
src/swpl_cmp.sv
src/sorted_word_prefix_lookup.sv
tb/sorted_word_prefix_lookup_tb.sv
